/* rtl/wss_pkg.sv */
// shared types and codes for the wake subscription scheduler
package wss_pkg;
  localparam logic [2:0] ACT_SUB   = 3'd0;
  localparam logic [2:0] ACT_UNSUB = 3'd1;
  localparam logic [2:0] ACT_FIRE  = 3'd2;
  localparam logic [2:0] ACT_DRAIN = 3'd3;
  localparam logic [2:0] ACT_COUNT = 3'd4;
  localparam logic [2:0] ACT_CLEAR = 3'd5;

  localparam logic [2:0] KIND_TIMER = 3'd0;
  localparam logic [2:0] KIND_EVENT = 3'd1;
  localparam logic [2:0] KIND_STATE = 3'd2;
  localparam logic [2:0] KIND_INIT  = 3'd3;
  localparam logic [2:0] KIND_EXPL  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int KEY_W  = 32;
  localparam int TICK_W = 64;

  typedef struct packed {
    logic [2:0]       kind;
    logic [5:0]       sys;
    logic [KEY_W-1:0] key;
    logic             fired;
  } entry_t;
endpackage

/* rtl/wake_subscription_scheduler_top.sv */
// wake subscription scheduler: subscription table, bit-serial timer match, runqueue drain
//
// one input word per action on in_valid/in_ready; results on out_valid/out_ready.
// every action gives one result word, except a drain that emits several ids,
// one word per id in ascending order, last set on the final word.
// the block works on one word at a time: in_ready is high only while idle.
// table actions walk the entries one per cycle, pausing while a timer fire
// match is in the remainder unit; the result word is registered after the walk.
// a timer fire computes tick mod period for each matching entry with a
// restoring remainder unit, one tick bit a cycle.
// a drain scans the 64 runqueue bits one per cycle, pausing to emit each queued id.
// when the receiver stalls, the output register holds and the result or id emit state waits.
// reset (rst_n low, synchronous) empties table valid bits and the runqueue;
// table payload is not cleared, entries are marked invalid.
module wake_subscription_scheduler_top
  import wss_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32,
  parameter int SYSTEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_kind,
  input  logic [5:0]  in_system_id,
  input  logic [31:0] in_match_key,
  input  logic [63:0] in_tick,
  input  logic [6:0]  in_capacity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_count,
  output logic [5:0]  out_woke_id,
  output logic        out_id_valid,
  output logic        out_last
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_RES   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DEMIT = 3'd5;

  logic [2:0] state_r;
  entry_t tbl_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [63:0] run_r;
  // number of ids queued in run_r
  logic [6:0]  run_cnt_r;

  logic [2:0]  act_r, kind_r;
  logic [5:0]  sys_r;
  logic [31:0] key_r;
  logic [63:0] tick_r;
  logic [IW-1:0] idx_r;
  logic [CW:0]   n_r;
  logic [IW-1:0] free_r;
  logic          free_ok_r;
  // remainder unit
  logic [32:0] rem_r;
  logic [6:0]  bit_r;
  // drain
  logic [6:0]  pos_r, emit_r, total_r;
  logic [63:0] scan_r;

  logic       ov_r;
  logic [1:0] os_r;
  logic [5:0] oc_r, oid_r;
  logic       oiv_r, ol_r;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_count = oc_r;
  assign out_woke_id = oid_r;
  assign out_id_valid = oiv_r;
  assign out_last = ol_r;

  entry_t cur;
  logic   cur_v, kmatch, idx_end, go_mod;
  logic [32:0] rem_sh;
  logic [5:0]  n_sat;
  logic [6:0]  cap_sat;
  logic [1:0]  res_st;
  logic [5:0]  res_cnt;
  logic        do_store;
  assign cur = tbl_r[idx_r];
  assign cur_v = vld_r[idx_r];
  assign kmatch = cur_v && (cur.kind == kind_r);
  assign idx_end = (idx_r == IW'(TABLE_ENTRIES - 1));
  assign go_mod = (act_r == ACT_FIRE) && kmatch && (kind_r == KIND_TIMER);
  assign rem_sh = {rem_r[31:0], tick_r[63]};
  assign n_sat = (n_r > (CW+1)'(63)) ? 6'd63 : 6'(n_r);
  assign cap_sat = (in_capacity > 7'd64) ? 7'd64 : in_capacity;

  // result word of a single-word action
  always_comb begin
    res_st = ST_OK;
    res_cnt = '0;
    do_store = 1'b0;
    case (act_r)
      ACT_SUB: begin
        if (kind_r > KIND_EXPL) res_cnt = '0;
        else if (kind_r == KIND_TIMER && key_r == '0) begin
          res_st = ST_ZERO; res_cnt = n_sat;
        end else if (SYSTEMS < 64 && 7'(sys_r) >= 7'(SYSTEMS)) begin
          res_cnt = n_sat;
        end else if (!free_ok_r) begin
          res_st = ST_FULL; res_cnt = n_sat;
        end else begin
          do_store = 1'b1;
          res_cnt = (n_r + 1'b1 > (CW+1)'(63)) ? 6'd63 : 6'(n_r + 1'b1);
        end
      end
      ACT_UNSUB, ACT_FIRE, ACT_COUNT: res_cnt = n_sat;
      default: ;
    endcase
  end

  wire ofree = !ov_r || out_ready;
  wire ov_set = ofree && ((state_r == S_RES) || (state_r == S_DEMIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= '0;
      run_r <= '0;
      run_cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_set || (ov_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            act_r <= in_action; kind_r <= in_kind; sys_r <= in_system_id;
            key_r <= in_match_key; tick_r <= in_tick;
            idx_r <= '0; n_r <= '0; free_ok_r <= 1'b0;
            pos_r <= '0; emit_r <= '0;
            unique case (in_action)
              ACT_SUB, ACT_UNSUB, ACT_FIRE, ACT_COUNT: state_r <= S_WALK;
              ACT_DRAIN: begin
                scan_r <= run_r;
                total_r <= (run_cnt_r < cap_sat) ? run_cnt_r : cap_sat;
                run_r <= '0;
                run_cnt_r <= '0;
                state_r <= S_DRAIN;
              end
              ACT_CLEAR: begin
                vld_r <= '0; run_r <= '0; run_cnt_r <= '0; state_r <= S_RES;
              end
              default: state_r <= S_RES;
            endcase
          end
        end
        S_WALK: begin
          state_r <= go_mod ? S_MOD : (idx_end ? S_RES : S_WALK);
          if (!idx_end && !go_mod) idx_r <= idx_r + 1'b1;
          unique case (act_r)
            ACT_SUB: begin
              if (!cur_v && !free_ok_r) begin
                free_ok_r <= 1'b1; free_r <= idx_r;
              end
              if (kmatch) n_r <= n_r + 1'b1;
            end
            ACT_COUNT: if (kmatch) n_r <= n_r + 1'b1;
            ACT_UNSUB: if (kmatch && cur.sys == sys_r) begin
              vld_r[idx_r] <= 1'b0; n_r <= n_r + 1'b1;
            end
            default: begin
              if (kmatch) begin
                case (kind_r)
                  KIND_TIMER: begin
                    rem_r <= '0; bit_r <= '0;
                  end
                  KIND_EVENT, KIND_STATE: if (cur.key == key_r) begin
                    n_r <= n_r + 1'b1; run_r[cur.sys] <= 1'b1;
                    if (!run_r[cur.sys]) run_cnt_r <= run_cnt_r + 1'b1;
                  end
                  KIND_INIT: if (!cur.fired) begin
                    n_r <= n_r + 1'b1; run_r[cur.sys] <= 1'b1;
                    if (!run_r[cur.sys]) run_cnt_r <= run_cnt_r + 1'b1;
                    tbl_r[idx_r].fired <= 1'b1;
                  end
                  KIND_EXPL: if (cur.key == key_r && cur.sys == sys_r) begin
                    n_r <= n_r + 1'b1; run_r[cur.sys] <= 1'b1;
                    if (!run_r[cur.sys]) run_cnt_r <= run_cnt_r + 1'b1;
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end
        S_MOD: begin
          // one tick bit per cycle, msb first; tick rotates back into place
          if (bit_r == 7'd64) begin
            if (rem_r == '0 && cur.key != '0) begin
              n_r <= n_r + 1'b1; run_r[cur.sys] <= 1'b1;
              if (!run_r[cur.sys]) run_cnt_r <= run_cnt_r + 1'b1;
            end
            if (idx_end) state_r <= S_RES;
            else begin
              idx_r <= idx_r + 1'b1; state_r <= S_WALK;
            end
          end else begin
            rem_r <= (rem_sh >= {1'b0, cur.key}) ? rem_sh - {1'b0, cur.key} : rem_sh;
            tick_r <= {tick_r[62:0], tick_r[63]};
            bit_r <= bit_r + 1'b1;
          end
        end
        S_RES: begin
          if (ofree) begin
            os_r <= res_st; oc_r <= res_cnt; oid_r <= '0;
            oiv_r <= 1'b0; ol_r <= 1'b1;
            state_r <= S_IDLE;
            if (do_store) begin
              vld_r[free_r] <= 1'b1;
              tbl_r[free_r] <= '{kind: kind_r, sys: sys_r,
                key: (kind_r == KIND_INIT) ? '0 : key_r, fired: 1'b0};
            end
          end
        end
        S_DRAIN: begin
          if (total_r == '0) state_r <= S_RES;
          else if (emit_r == total_r || pos_r == 7'd64) state_r <= S_IDLE;
          else if (scan_r[0]) state_r <= S_DEMIT;
          else begin
            scan_r <= {1'b0, scan_r[63:1]}; pos_r <= pos_r + 1'b1;
          end
        end
        S_DEMIT: begin
          if (ofree) begin
            os_r <= ST_OK;
            oc_r <= (total_r > 7'd63) ? 6'd63 : 6'(total_r);
            oid_r <= 6'(pos_r); oiv_r <= 1'b1;
            ol_r <= (emit_r + 1'b1 == total_r);
            emit_r <= emit_r + 1'b1;
            scan_r <= {1'b0, scan_r[63:1]}; pos_r <= pos_r + 1'b1;
            state_r <= S_DRAIN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* bench/tb_top.sv */
// self-checking testbench for the wake subscription scheduler
`timescale 1ns / 100ps

class wake_scoreboard;
  typedef struct {
    logic [1:0] status;
    logic [5:0] count;
    logic [5:0] woke_id;
    logic       id_valid;
    logic       last;
  } result_t;

  // shadow of the subscription table and runqueue
  bit         ent_valid[32];
  bit [2:0]   ent_kind[32];
  bit [5:0]   ent_sys[32];
  bit [31:0]  ent_key[32];
  bit         ent_fired[32];
  bit [63:0]  runq;
  result_t    pending[$];
  int         errors;
  int         results_seen;

  function void clear_all();
    for (int i = 0; i < 32; i++) ent_valid[i] = 0;
    runq = '0;
  endfunction

  function int kind_total(bit [2:0] k);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) if (ent_valid[i] && ent_kind[i] == k) n++;
    return n;
  endfunction

  function bit [5:0] sat(int n);
    return (n > 63) ? 6'd63 : n[5:0];
  endfunction

  function void push(bit [1:0] st, bit [5:0] cnt, bit [5:0] id, bit v, bit l);
    result_t r;
    r.status = st; r.count = cnt; r.woke_id = id; r.id_valid = v; r.last = l;
    pending = {pending, r};
  endfunction

  function void note_word(bit [2:0] act, bit [2:0] kind, bit [5:0] sys,
                          bit [31:0] key, bit [63:0] tick, bit [6:0] cap);
    int n, slot, c;
    bit hit;
    int ids[$];
    n = 0;
    case (act)
      wss_pkg::ACT_SUB: begin
        if (kind > wss_pkg::KIND_EXPL) push(wss_pkg::ST_OK, 0, 0, 0, 1);
        else if (kind == wss_pkg::KIND_TIMER && key == 0)
          push(wss_pkg::ST_ZERO, sat(kind_total(kind)), 0, 0, 1);
        else begin
          slot = -1;
          for (int i = 0; i < 32; i++) if (!ent_valid[i] && slot < 0) slot = i;
          if (slot < 0) push(wss_pkg::ST_FULL, sat(kind_total(kind)), 0, 0, 1);
          else begin
            ent_valid[slot] = 1; ent_kind[slot] = kind; ent_sys[slot] = sys;
            ent_key[slot] = (kind == wss_pkg::KIND_INIT) ? 32'd0 : key;
            ent_fired[slot] = 0;
            push(wss_pkg::ST_OK, sat(kind_total(kind)), 0, 0, 1);
          end
        end
      end
      wss_pkg::ACT_UNSUB: begin
        for (int i = 0; i < 32; i++)
          if (ent_valid[i] && ent_kind[i] == kind && ent_sys[i] == sys) begin
            ent_valid[i] = 0; n++;
          end
        push(wss_pkg::ST_OK, sat(n), 0, 0, 1);
      end
      wss_pkg::ACT_FIRE: begin
        for (int i = 0; i < 32; i++) begin
          hit = 0;
          if (ent_valid[i] && ent_kind[i] == kind) begin
            case (kind)
              wss_pkg::KIND_TIMER: hit = ent_key[i] != 0 && (tick % ent_key[i]) == 0;
              wss_pkg::KIND_EVENT, wss_pkg::KIND_STATE: hit = ent_key[i] == key;
              wss_pkg::KIND_INIT: begin
                hit = !ent_fired[i];
                ent_fired[i] = 1;
              end
              wss_pkg::KIND_EXPL: hit = ent_sys[i] == sys && ent_key[i] == key;
              default: hit = 0;
            endcase
          end
          if (hit) begin
            runq[ent_sys[i]] = 1; n++;
          end
        end
        push(wss_pkg::ST_OK, sat(n), 0, 0, 1);
      end
      wss_pkg::ACT_DRAIN: begin
        c = (cap > 64) ? 64 : cap;
        for (int i = 0; i < 64; i++) if (runq[i] && ids.size() < c) ids = {ids, i};
        runq = '0;
        if (ids.size() == 0) push(wss_pkg::ST_OK, 0, 0, 0, 1);
        else foreach (ids[k])
          push(wss_pkg::ST_OK, sat(ids.size()), ids[k], 1, k == ids.size() - 1);
      end
      wss_pkg::ACT_COUNT:
        push(wss_pkg::ST_OK, kind <= wss_pkg::KIND_EXPL ? sat(kind_total(kind)) : 6'd0,
             0, 0, 1);
      wss_pkg::ACT_CLEAR: begin
        clear_all();
        push(wss_pkg::ST_OK, 0, 0, 0, 1);
      end
      default: push(wss_pkg::ST_OK, 0, 0, 0, 1);
    endcase
  endfunction

  function void check_word(logic [1:0] st, logic [5:0] cnt, logic [5:0] id,
                           logic v, logic l);
    result_t e;
    results_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word st=%0d cnt=%0d id=%0d v=%0d l=%0d",
               $time, st, cnt, id, v, l);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (st !== e.status || cnt !== e.count || id !== e.woke_id ||
        v !== e.id_valid || l !== e.last) begin
      $display("%0t: mismatch exp st/cnt/id/v/l=%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
               $time, e.status, e.count, e.woke_id, e.id_valid, e.last,
               st, cnt, id, v, l);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import wss_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_action = '0;
  logic [2:0]  in_kind = '0;
  logic [5:0]  in_system_id = '0;
  logic [31:0] in_match_key = '0;
  logic [63:0] in_tick = '0;
  logic [6:0]  in_capacity = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic [5:0]  out_count;
  logic [5:0]  out_woke_id;
  logic        out_id_valid;
  logic        out_last;

  wake_subscription_scheduler_top uut (.*);

  wake_scoreboard board = new();
  bit sink_calm;
  int words_sent;

  initial forever #4 clk = ~clk;

  // receiver: random stalls per word, calm stretches in between
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = sink_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk iff out_valid);
      board.check_word(out_status, out_count, out_woke_id, out_id_valid, out_last);
    end
  end

  task automatic send_word(bit [2:0] act, bit [2:0] kind, bit [5:0] sys,
                           bit [31:0] key, bit [63:0] tick, bit [6:0] cap,
                           bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_action <= act; in_kind <= kind; in_system_id <= sys;
    in_match_key <= key; in_tick <= tick; in_capacity <= cap;
    @(posedge clk iff in_ready);
    board.note_word(act, kind, sys, key, tick, cap);
    words_sent++;
  endtask

  task automatic send_random(bit calm);
    bit [2:0] act, kind;
    bit [31:0] key;
    bit [63:0] tick;
    int r;
    r = $urandom_range(0, 99);
    act = r < 40 ? ACT_SUB : r < 50 ? ACT_UNSUB : r < 75 ? ACT_FIRE :
          r < 87 ? ACT_DRAIN : r < 93 ? ACT_COUNT : r < 96 ? ACT_CLEAR :
          3'($urandom_range(6, 7));
    kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    // small keys so that fires hit often; sometimes full-width noise
    key = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 5);
    tick = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 60));
    send_word(act, kind, 6'($urandom_range(0, 63)), key, tick,
              7'($urandom_range(0, 127)), calm);
  endtask

  initial begin
    int t;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: each action, extremes, special cases
    send_word(ACT_DRAIN, KIND_TIMER, 0, 0, 0, 64, 0);
    send_word(ACT_SUB, KIND_TIMER, 5, 0, 0, 0, 0);
    send_word(ACT_SUB, KIND_TIMER, 63, 32'hFFFF_FFFF, 0, 0, 0);
    send_word(ACT_SUB, KIND_TIMER, 0, 3, 0, 0, 0);
    send_word(ACT_SUB, KIND_EVENT, 7, 9, 0, 0, 0);
    send_word(ACT_SUB, KIND_STATE, 8, 9, 0, 0, 0);
    send_word(ACT_SUB, KIND_INIT, 9, 32'hDEAD, 0, 0, 0);
    send_word(ACT_SUB, KIND_EXPL, 10, 4, 0, 0, 0);
    send_word(ACT_SUB, 3'd7, 11, 1, 0, 0, 0);
    send_word(ACT_FIRE, KIND_TIMER, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_word(ACT_FIRE, KIND_TIMER, 0, 0, 0, 0, 0);
    send_word(ACT_FIRE, KIND_EVENT, 0, 9, 0, 0, 0);
    send_word(ACT_FIRE, KIND_STATE, 0, 9, 0, 0, 0);
    send_word(ACT_FIRE, KIND_INIT, 0, 0, 0, 0, 0);
    send_word(ACT_FIRE, KIND_INIT, 0, 0, 0, 0, 0);
    send_word(ACT_FIRE, KIND_EXPL, 10, 4, 0, 0, 0);
    send_word(ACT_FIRE, 3'd6, 10, 4, 0, 0, 0);
    send_word(ACT_DRAIN, KIND_TIMER, 0, 0, 0, 2, 0);
    send_word(ACT_COUNT, KIND_TIMER, 0, 0, 0, 0, 0);
    send_word(ACT_COUNT, 3'd5, 0, 0, 0, 0, 0);
    send_word(ACT_UNSUB, KIND_TIMER, 63, 0, 0, 0, 0);
    send_word(3'd6, 0, 0, 0, 0, 0, 0);
    send_word(3'd7, 3'd7, 6'd63, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 0);
    // fill the table past full, then drain a wide queue
    for (int i = 0; i < 34; i++) send_word(ACT_SUB, KIND_EVENT, 6'(i * 2 + 1), 1, 0, 0, 1);
    send_word(ACT_FIRE, KIND_EVENT, 0, 1, 0, 0, 0);
    send_word(ACT_DRAIN, 0, 0, 0, 0, 7'd127, 0);
    send_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    in_valid <= 0;
    // hold off until everything has drained out
    wait (board.pending.size() == 0);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 50; i++) begin
      sink_calm = (i >= 20 && i < 35);
      send_random(sink_calm);
    end
    in_valid <= 0;
    sink_calm = 0;
    t = 0;
    while (board.pending.size() != 0 && t < 400000) begin
      @(posedge clk); t++;
    end
    repeat (2500) @(posedge clk);
    $display("sent %0d words, checked %0d result words across all actions and kinds",
             words_sent, board.results_seen);
    if (board.errors == 0 && board.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
